/* rtl/kpc_pkg.sv */
// shared types and constants for the key press classifier
// used by kpc_key_cell and key_press_classifier; no dependencies
`default_nettype none

package kpc_pkg;

    localparam int DEF_NUM_KEYS    = 4;
    localparam int DEF_RELEASE_CAP = 100;

    localparam int LEVEL_BITS  = 4;
    localparam int COUNT_W     = 16;
    localparam int REL_W       = 7;
    localparam int CODE_W      = 3;
    localparam int SUM_W       = 5;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CODE_W-1:0] CODE_NONE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_SHORT   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_LONG    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_DOUBLE  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_INVALID = 3'd4;

    localparam logic FUNC_SCAN  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [2:0] CLEAR_ALL = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_LIMIT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_LIMIT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_GAP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_ENABLE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MANUAL_CLEAR  = 3'd4;

    localparam logic [COUNT_W-1:0] RST_SHORT_LIMIT = 16'd50;
    localparam logic [COUNT_W-1:0] RST_LONG_LIMIT  = 16'd100;
    localparam logic [REL_W-1:0]   RST_DOUBLE_GAP  = 7'd30;

    typedef struct packed {
        logic                  func;
        logic [LEVEL_BITS-1:0] key_levels;
        logic [2:0]            clear_target;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] status_key0;
        logic [CODE_W-1:0] status_key1;
        logic [CODE_W-1:0] status_key2;
        logic [CODE_W-1:0] status_key3;
        logic [SUM_W-1:0]  status_sum;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] short_limit;
        logic [COUNT_W-1:0] long_limit;
        logic [REL_W-1:0]   double_gap;
        logic               double_enable;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic clear;
        logic released;
        logic auto_clear;
    } key_ctrl_t;

endpackage

`default_nettype wire

/* rtl/key_press_classifier.sv */
// top level: configuration registers, per-key cells and the result register
// depends on kpc_pkg and kpc_key_cell
// an accepted transaction's result is registered into out_data in the cycle after it is accepted
// throughput: one transaction per cycle; in_stall only while a result waits under out_stall
// reset: counters zero, key values invalid, status none, registers at their defaults
`default_nettype none

module key_press_classifier #(
    parameter int NUM_KEYS    = kpc_pkg::DEF_NUM_KEYS,
    parameter int RELEASE_CAP = kpc_pkg::DEF_RELEASE_CAP
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire  [kpc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [kpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  kpc_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output kpc_pkg::out_item_t                  out_data
);
    import kpc_pkg::*;

    cfg_t        cfg_reg;
    logic        manual_clear_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;

    logic        accept;
    logic        any_released;
    logic [CODE_W-1:0] status_next [NUM_KEYS];
    logic [CODE_W-1:0] status_pad  [LEVEL_BITS];
    logic [SUM_W-1:0]  sum_next;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_limit   <= RST_SHORT_LIMIT;
            cfg_reg.long_limit    <= RST_LONG_LIMIT;
            cfg_reg.double_gap    <= RST_DOUBLE_GAP;
            cfg_reg.double_enable <= 1'b1;
            manual_clear_reg      <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SHORT_LIMIT:   cfg_reg.short_limit   <= cfg_wdata;
                REG_LONG_LIMIT:    cfg_reg.long_limit    <= cfg_wdata;
                REG_DOUBLE_GAP:    cfg_reg.double_gap    <= cfg_wdata[REL_W-1:0];
                REG_DOUBLE_ENABLE: cfg_reg.double_enable <= cfg_wdata[0];
                REG_MANUAL_CLEAR:  manual_clear_reg      <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        any_released = (NUM_KEYS > LEVEL_BITS);
        for (int k = 0; k < LEVEL_BITS; k++)
        begin
            if (k < NUM_KEYS && in_data.key_levels[k])
            begin
                any_released = 1'b1;
            end
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        key_ctrl_t ctrl;
        always_comb
        begin
            ctrl.tick       = accept && (in_data.func == FUNC_SCAN);
            ctrl.clear      = accept && (in_data.func == FUNC_CLEAR)
                              && (in_data.clear_target == CLEAR_ALL
                                  || int'(in_data.clear_target) == k);
            ctrl.released   = (k >= LEVEL_BITS) ? 1'b1 : in_data.key_levels[k % LEVEL_BITS];
            ctrl.auto_clear = any_released && !manual_clear_reg;
        end

        kpc_key_cell #(
            .RELEASE_CAP (RELEASE_CAP)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg         (cfg_reg),
            .ctrl        (ctrl),
            .status_next (status_next[k])
        );
    end

    for (genvar k = 0; k < LEVEL_BITS; k++)
    begin : g_pad
        if (k < NUM_KEYS)
        begin : g_used
            assign status_pad[k] = status_next[k];
        end
        else
        begin : g_unused
            assign status_pad[k] = CODE_NONE;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            sum_next = sum_next + SUM_W'(status_next[k]);
        end
        out_data_next.status_key0 = status_pad[0];
        out_data_next.status_key1 = status_pad[1];
        out_data_next.status_key2 = status_pad[2];
        out_data_next.status_key3 = status_pad[3];
        out_data_next.status_sum  = sum_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // every accepted transaction leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted transaction produced no result");

    // published codes stay within the code set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status_key0 <= CODE_INVALID
                       && out_data.status_key1 <= CODE_INVALID
                       && out_data.status_key2 <= CODE_INVALID
                       && out_data.status_key3 <= CODE_INVALID))
        else $error("status code out of range");

    // sum matches the fields when every key has a field
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (NUM_KEYS > LEVEL_BITS
                       || out_data.status_sum == SUM_W'(out_data.status_key0)
                          + SUM_W'(out_data.status_key1)
                          + SUM_W'(out_data.status_key2)
                          + SUM_W'(out_data.status_key3)))
        else $error("status sum disagrees with status fields");

endmodule

`default_nettype wire

/* rtl/kpc_key_cell.sv */
// one key: press, release, gap and effect counters, classification and status
// depends on kpc_pkg
`default_nettype none

module kpc_key_cell #(
    parameter int RELEASE_CAP = kpc_pkg::DEF_RELEASE_CAP
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  kpc_pkg::cfg_t                     cfg,
    input  kpc_pkg::key_ctrl_t                ctrl,
    output logic [kpc_pkg::CODE_W-1:0]        status_next
);
    import kpc_pkg::*;

    localparam logic [REL_W-1:0]   CAP       = REL_W'(RELEASE_CAP);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [COUNT_W-1:0] press_reg,  press_next;
    logic [REL_W-1:0]   release_reg, release_next;
    logic [REL_W-1:0]   gap_reg,    gap_next;
    logic [COUNT_W-1:0] effect_reg, effect_next;
    logic [CODE_W-1:0]  value_reg,  value_next;
    logic [CODE_W-1:0]  status_reg;

    always_comb
    begin
        press_next   = press_reg;
        release_next = release_reg;
        gap_next     = gap_reg;
        effect_next  = effect_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        if (ctrl.tick)
        begin
            if (!ctrl.released)
            begin
                if (release_reg != '0)
                begin
                    gap_next = release_reg;
                end
                if (press_reg != COUNT_MAX)
                begin
                    press_next = press_reg + 1'b1;
                end
                release_next = '0;
                if (press_next > cfg.long_limit)
                begin
                    effect_next = press_next;
                end
            end
            else
            begin
                if (press_reg != '0)
                begin
                    effect_next = press_reg;
                end
                if (release_reg < CAP)
                begin
                    release_next = release_reg + 1'b1;
                end
                press_next = '0;
            end
            if (ctrl.auto_clear)
            begin
                value_next = CODE_NONE;
            end
            if (effect_next != '0 && effect_next < cfg.short_limit)
            begin
                if (cfg.double_enable && gap_next != '0 && gap_next < cfg.double_gap)
                begin
                    value_next = CODE_DOUBLE;
                    gap_next   = '0;
                end
                else
                begin
                    value_next = CODE_SHORT;
                end
                effect_next = '0;
            end
            else if (effect_next > cfg.long_limit)
            begin
                value_next  = CODE_LONG;
                effect_next = '0;
            end
            if (!cfg.double_enable || release_next > cfg.double_gap)
            begin
                status_next = value_next;
            end
        end
        else if (ctrl.clear)
        begin
            value_next = CODE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_reg   <= '0;
            release_reg <= '0;
            gap_reg     <= '0;
            effect_reg  <= '0;
            value_reg   <= CODE_INVALID;
            status_reg  <= CODE_NONE;
        end
        else
        begin
            press_reg   <= press_next;
            release_reg <= release_next;
            gap_reg     <= gap_next;
            effect_reg  <= effect_next;
            value_reg   <= value_next;
            status_reg  <= status_next;
        end
    end

endmodule

`default_nettype wire

/* verif/key_press_classifier_tb.sv */
// testbench for key_press_classifier: directed and random scan ticks and clear commands
// checks every result against an in-bench predictor of the per-key classification
// depends on kpc_pkg and the key_press_classifier rtl
`timescale 1ns / 1ps

module key_press_classifier_tb;
    import kpc_pkg::*;

    localparam int NKEYS = DEF_NUM_KEYS;
    localparam logic [REL_W-1:0] REL_CAP = REL_W'(DEF_RELEASE_CAP);
    localparam logic [LEVEL_BITS-1:0] ALL_PRESSED  = 4'h0;
    localparam logic [LEVEL_BITS-1:0] ALL_RELEASED = 4'hF;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_PRINTS  = 50;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;

    key_press_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor state
    logic [COUNT_W-1:0] lim_short, lim_long;
    logic [REL_W-1:0]   dbl_gap;
    logic               dbl_en, manual_clr;
    logic [COUNT_W-1:0] press_ticks [NKEYS];
    logic [REL_W-1:0]   rel_ticks   [NKEYS];
    logic [REL_W-1:0]   gap_ticks   [NKEYS];
    logic [COUNT_W-1:0] eff_ticks   [NKEYS];
    logic [CODE_W-1:0]  key_code    [NKEYS];
    logic [CODE_W-1:0]  key_pub     [NKEYS];

    out_item_t expected_status [$];
    int errors = 0;
    int idle_pct = 0;
    int quiet_cycles = 0;

    // random press/release sequencing per key
    bit seq_down [NKEYS];
    int seq_left [NKEYS];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void reset_predictor();
        lim_short  = RST_SHORT_LIMIT;
        lim_long   = RST_LONG_LIMIT;
        dbl_gap    = RST_DOUBLE_GAP;
        dbl_en     = 1'b1;
        manual_clr = 1'b0;
        for (int k = 0; k < NKEYS; k++)
        begin
            press_ticks[k] = '0;
            rel_ticks[k]   = '0;
            gap_ticks[k]   = '0;
            eff_ticks[k]   = '0;
            key_code[k]    = CODE_INVALID;
            key_pub[k]     = CODE_NONE;
        end
    endfunction

    function automatic out_item_t classify_item(in_item_t item);
        out_item_t res;
        logic any_up;
        logic [SUM_W-1:0] total;
        any_up = 1'b0;
        total = '0;
        if (item.func == FUNC_SCAN)
        begin
            for (int k = 0; k < NKEYS; k++)
            begin
                if (!item.key_levels[k])
                begin
                    if (rel_ticks[k] != 0)
                        gap_ticks[k] = rel_ticks[k];
                    if (press_ticks[k] != 16'hFFFF)
                        press_ticks[k] = press_ticks[k] + 1'b1;
                    rel_ticks[k] = '0;
                    if (press_ticks[k] > lim_long)
                        eff_ticks[k] = press_ticks[k];
                end
                else
                begin
                    if (press_ticks[k] != 0)
                        eff_ticks[k] = press_ticks[k];
                    if (rel_ticks[k] < REL_CAP)
                        rel_ticks[k] = rel_ticks[k] + 1'b1;
                    press_ticks[k] = '0;
                    any_up = 1'b1;
                end
            end
            if (any_up && !manual_clr)
            begin
                for (int k = 0; k < NKEYS; k++)
                    key_code[k] = CODE_NONE;
            end
            for (int k = 0; k < NKEYS; k++)
            begin
                if (eff_ticks[k] != 0 && eff_ticks[k] < lim_short)
                begin
                    if (dbl_en && gap_ticks[k] != 0 && gap_ticks[k] < dbl_gap)
                    begin
                        key_code[k]  = CODE_DOUBLE;
                        gap_ticks[k] = '0;
                    end
                    else
                    begin
                        key_code[k] = CODE_SHORT;
                    end
                    eff_ticks[k] = '0;
                end
                else if (eff_ticks[k] > lim_long)
                begin
                    key_code[k]  = CODE_LONG;
                    eff_ticks[k] = '0;
                end
                if (!dbl_en || rel_ticks[k] > dbl_gap)
                    key_pub[k] = key_code[k];
            end
        end
        else if (item.clear_target == CLEAR_ALL)
        begin
            for (int k = 0; k < NKEYS; k++)
                key_code[k] = CODE_NONE;
        end
        else if (item.clear_target < NKEYS)
        begin
            key_code[item.clear_target] = CODE_NONE;
        end
        for (int k = 0; k < NKEYS; k++)
            total = total + SUM_W'(key_pub[k]);
        res.status_key0 = key_pub[0];
        res.status_key1 = key_pub[1];
        res.status_key2 = key_pub[2];
        res.status_key3 = key_pub[3];
        res.status_sum  = total;
        return res;
    endfunction

    function automatic in_item_t scan_item(logic [LEVEL_BITS-1:0] levels);
        in_item_t item;
        item.func         = FUNC_SCAN;
        item.key_levels   = levels;
        item.clear_target = 3'($urandom_range(7));
        return item;
    endfunction

    function automatic in_item_t clear_item(logic [2:0] target);
        in_item_t item;
        item.func         = FUNC_CLEAR;
        item.key_levels   = 4'($urandom);
        item.clear_target = target;
        return item;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_item(in_item_t item);
        @(negedge clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_status.push_back(classify_item(item));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_SHORT_LIMIT:   lim_short  = data;
            REG_LONG_LIMIT:    lim_long   = data;
            REG_DOUBLE_GAP:    dbl_gap    = data[REL_W-1:0];
            REG_DOUBLE_ENABLE: dbl_en     = data[0];
            REG_MANUAL_CLEAR:  manual_clr = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(int s_lim, int l_lim, int gap, bit dbl, bit man);
        wait_drained();
        write_reg(REG_SHORT_LIMIT, CFG_DATA_W'(s_lim));
        write_reg(REG_LONG_LIMIT, CFG_DATA_W'(l_lim));
        write_reg(REG_DOUBLE_GAP, CFG_DATA_W'(gap));
        write_reg(REG_DOUBLE_ENABLE, CFG_DATA_W'(dbl));
        write_reg(REG_MANUAL_CLEAR, CFG_DATA_W'(man));
    endtask

    function automatic int span(int lo, int hi);
        if (lo < 1)
            lo = 1;
        if (lo > 120)
            lo = 120;
        if (hi > lo + 30)
            hi = lo + 30;
        if (hi < lo)
            hi = lo;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int press_len();
        case ($urandom_range(2))
            0: return span(1, int'(lim_short) - 1);
            1: return span(int'(lim_short), int'(lim_long));
            default: return span(int'(lim_long) + 1, int'(lim_long) + 4);
        endcase
    endfunction

    function automatic int release_len();
        case ($urandom_range(3))
            0, 1: return span(1, int'(dbl_gap) - 1);
            2: return span(int'(dbl_gap), int'(dbl_gap) + 2);
            default: return span(int'(REL_CAP) - 2, int'(REL_CAP) + 3);
        endcase
    endfunction

    function automatic logic [LEVEL_BITS-1:0] next_levels();
        logic [LEVEL_BITS-1:0] lv;
        lv = ALL_RELEASED;
        for (int k = 0; k < NKEYS; k++)
        begin
            if (seq_left[k] == 0)
            begin
                seq_down[k] = !seq_down[k];
                seq_left[k] = seq_down[k] ? press_len() : release_len();
            end
            lv[k] = !seq_down[k];
            seq_left[k]--;
        end
        return lv;
    endfunction

    // codes published with double detection off, then every clear target
    task automatic test_codes_and_clears();
        apply_config(50, 100, 30, 1'b0, 1'b0);
        send_item(scan_item(ALL_PRESSED));
        send_item(clear_item(3'd5));
        send_item(clear_item(3'd6));
        send_item(clear_item(3'd7));
        send_item(clear_item(3'd1));
        send_item(scan_item(ALL_PRESSED));
        send_item(clear_item(CLEAR_ALL));
        send_item(scan_item(ALL_PRESSED));
        send_item(scan_item(ALL_RELEASED));
        send_item(scan_item(ALL_RELEASED));
        send_item(scan_item(4'hA));
        send_item(scan_item(4'h5));
        send_item(clear_item(3'd0));
        send_item(clear_item(3'd2));
        send_item(clear_item(3'd3));
        send_item(scan_item(ALL_RELEASED));
    endtask

    // short press, quick re-press, then a long press, with delayed publishing
    task automatic test_double_press();
        apply_config(4, 8, 3, 1'b1, 1'b0);
        repeat (2) send_item(scan_item(4'hE));
        send_item(scan_item(ALL_RELEASED));
        repeat (2) send_item(scan_item(4'hE));
        repeat (5) send_item(scan_item(ALL_RELEASED));
        repeat (9) send_item(scan_item(4'hE));
        repeat (5) send_item(scan_item(ALL_RELEASED));
    endtask

    // key 0 held well past the long limit, back to back with no idling
    task automatic test_long_hold();
        apply_config(50, 100, 30, 1'b0, 1'b1);
        idle_pct = 0;
        repeat (120) send_item(scan_item(4'hE));
        repeat (3) send_item(scan_item(ALL_RELEASED));
    endtask

    task automatic test_random_phase(int s_lim, int l_lim, int gap, bit dbl, bit man,
                                     int count, int idle);
        int pick;
        apply_config(s_lim, l_lim, gap, dbl, man);
        idle_pct = idle;
        for (int k = 0; k < NKEYS; k++)
        begin
            seq_down[k] = 1'b0;
            seq_left[k] = $urandom_range(3);
        end
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_item(clear_item(3'($urandom_range(7))));
            else if (pick < 18)
                send_item(scan_item(4'($urandom)));
            else
                send_item(scan_item(next_levels()));
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                report_mismatch("unexpected transaction, sum", out_data.status_sum, 0);
            end
            else
            begin
                want = expected_status.pop_front();
                if (out_data.status_key0 !== want.status_key0)
                    report_mismatch("status_key0", out_data.status_key0, want.status_key0);
                if (out_data.status_key1 !== want.status_key1)
                    report_mismatch("status_key1", out_data.status_key1, want.status_key1);
                if (out_data.status_key2 !== want.status_key2)
                    report_mismatch("status_key2", out_data.status_key2, want.status_key2);
                if (out_data.status_key3 !== want.status_key3)
                    report_mismatch("status_key3", out_data.status_key3, want.status_key3);
                if (out_data.status_sum !== want.status_sum)
                    report_mismatch("status_sum", out_data.status_sum, want.status_sum);
            end
        end
    end

    always @(negedge clk)
        out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);

    // watchdog on cycles with no accepted transaction and no delivered result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        reset_predictor();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        idle_pct = 32;
        test_codes_and_clears();
        test_double_press();
        test_long_hold();
        test_random_phase(6, 10, 5, 1'b1, 1'b0, 500, 32);
        test_random_phase(6, 10, 5, 1'b1, 1'b1, 400, 32);
        test_random_phase(6, 10, 5, 1'b0, 1'b0, 300, 0);
        test_random_phase(1, 1, 1, 1'b1, 1'b0, 200, 32);
        test_random_phase(65535, 65535, 100, 1'b1, 1'b1, 200, 32);
        test_random_phase(50, 100, 30, 1'b1, 1'b0, 300, 32);
        wait_drained();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
